### sv/iowt_pkg.sv
// Shared types and codes of the I/O wait table.
package iowt_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;

   localparam logic [1:0] STATUS_PARKED  = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_WAKE    = 2'd2;

   localparam int EV_READ_BIT  = 0;
   localparam int EV_WRITE_BIT = 1;

   localparam logic MODE_PARK = 1'b0;
   localparam logic MODE_WAKE = 1'b1;

endpackage

### sv/io_wait_table.sv
// Top level of the I/O wait table: handle lookup, park and wake sequencer.
//
// io_wait_table keeps TABLE_SLOTS entries, each binding one file handle to at
// most one waiting reader task and one waiting writer task. A park item
// (mode 0) finds the entry of its handle or claims the lowest free slot and
// records the task in each requested direction; it is refused when the event
// mask is empty, shutdown is set, the table is full, or a requested direction
// is already taken. A wake item (mode 1) releases the waiters whose direction
// is ready, names a task waiting in both directions once, frees the entry
// when nothing is left waiting, and gives one result per woken task (reader
// first) or a single result when nobody is woken. Timing: handle, reader task
// and writer task live in one RAM with one read port, so lookup scans one
// slot per cycle; the scan ends early when the handle is found, and a park
// refused on its mask or on shutdown skips the scan; results are then shown
// one at a time, and req_ready returns in the cycle after the last result is
// accepted. Only one item is in flight. The used and valid bits sit in
// flip-flops cleared by reset, so there is no clearing pass. A csr write loads
// csr_wdata into shutdown; csr_ready is always high.
module io_wait_table #(
   parameter int TABLE_SLOTS = 64,
   parameter int HANDLE_BITS = 16,
   parameter int TASK_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [HANDLE_BITS-1:0] req_handle,
   input  logic [1:0]             req_event_mask,
   input  logic [TASK_BITS-1:0]   req_task_id,
   input  logic                   req_success_flag,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic                   rsp_woken_valid,
   output logic [TASK_BITS-1:0]   rsp_woken_task,
   output logic                   rsp_woken_success,
   output logic [1:0]             rsp_old_interest,
   output logic [1:0]             rsp_new_interest,
   output logic                   rsp_last
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int ENT_W = HANDLE_BITS + 2 * TASK_BITS;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [TASK_BITS-1:0]   rtask;
      logic [TASK_BITS-1:0]   wtask;
   } entry_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 woken_valid;
      logic [TASK_BITS-1:0] woken_task;
      logic                 woken_success;
      logic [1:0]           old_interest;
      logic [1:0]           new_interest;
      logic                 last;
   } rsp_type;

   // sequencer state
   iowt_pkg::state_type state_ff, state_in;

   // latched item
   logic                   mode_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [1:0]             ev_ff;
   logic [TASK_BITS-1:0]   task_ff;
   logic                   succ_ff;

   // scan pipeline
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             chk_vld_ff, chk_vld_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type        entry_ff, entry_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // per-slot flags
   logic [TABLE_SLOTS-1:0] used_ff, used_in;
   logic [TABLE_SLOTS-1:0] rvalid_ff, rvalid_in;
   logic [TABLE_SLOTS-1:0] wvalid_ff, wvalid_in;

   logic shutdown_ff;

   // result registers
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type pend_ff, pend_in;
   logic    pend_vld_ff, pend_vld_in;

   // RAM port
   logic             ram_rd_en;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic [ENT_W-1:0] ram_rd_raw;
   entry_type        ram_rd_data;

   // update-cycle terms
   logic [IDX_W-1:0] sel_idx;
   logic             have_slot;
   logic             cur_rv, cur_wv;
   logic             park_refuse;
   logic             wake_r, wake_w, wv_mid;
   logic             rv_new, wv_new;
   logic [1:0]       old_int, park_int, wake_int;

   logic req_acc;

   assign req_acc   = req_valid && req_ready;
   assign req_ready = (state_ff == iowt_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   iowt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = entry_type'(ram_rd_raw);

   // slot chosen by the scan: the handle's entry, else the lowest free one
   always_comb begin
      sel_idx   = found_ff ? hit_idx_ff : free_idx_ff;
      have_slot = found_ff || free_found_ff;
      cur_rv    = found_ff ? rvalid_ff[sel_idx] : 1'b0;
      cur_wv    = found_ff ? wvalid_ff[sel_idx] : 1'b0;
      old_int   = {cur_wv, cur_rv};

      park_refuse = (ev_ff == 2'b00) || shutdown_ff || !have_slot ||
                    (ev_ff[iowt_pkg::EV_READ_BIT]  && cur_rv) ||
                    (ev_ff[iowt_pkg::EV_WRITE_BIT] && cur_wv);
      park_int    = {cur_wv | ev_ff[iowt_pkg::EV_WRITE_BIT],
                     cur_rv | ev_ff[iowt_pkg::EV_READ_BIT]};

      // reader first; a writer with the same task goes with it
      wake_r = ev_ff[iowt_pkg::EV_READ_BIT] && cur_rv;
      rv_new = cur_rv && !wake_r;
      wv_mid = cur_wv && !(wake_r && (entry_ff.wtask == entry_ff.rtask));
      wake_w = ev_ff[iowt_pkg::EV_WRITE_BIT] && wv_mid;
      wv_new = wv_mid && !wake_w;
      wake_int = {wv_new, rv_new};
   end

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = 1'b0;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      entry_in      = entry_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      used_in       = used_ff;
      rvalid_in     = rvalid_ff;
      wvalid_in     = wvalid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sel_idx;
      ram_wr_data   = '{handle: handle_ff,
                        rtask: ev_ff[iowt_pkg::EV_READ_BIT]  ? task_ff : entry_ff.rtask,
                        wtask: ev_ff[iowt_pkg::EV_WRITE_BIT] ? task_ff : entry_ff.wtask};

      unique case (state_ff)
         iowt_pkg::ST_IDLE: begin
            if (req_acc) begin
               rd_idx_in     = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               // a park refused on its mask or on shutdown needs no lookup
               if (req_mode == iowt_pkg::MODE_PARK &&
                   (req_event_mask == 2'b00 || shutdown_ff)) begin
                  state_in = iowt_pkg::ST_UPDATE;
               end else begin
                  state_in = iowt_pkg::ST_SCAN;
               end
            end
         end

         iowt_pkg::ST_SCAN: begin
            ram_rd_en  = (rd_idx_ff < CNT_W'(TABLE_SLOTS));
            chk_vld_in = ram_rd_en;
            chk_idx_in = rd_idx_ff[IDX_W-1:0];
            if (ram_rd_en) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               if (used_ff[chk_idx_ff] && ram_rd_data.handle == handle_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  entry_in   = ram_rd_data;
                  chk_vld_in = 1'b0;
                  state_in   = iowt_pkg::ST_UPDATE;
               end else begin
                  if (!used_ff[chk_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = chk_idx_ff;
                  end
                  if (chk_idx_ff == IDX_W'(TABLE_SLOTS - 1)) begin
                     state_in = iowt_pkg::ST_UPDATE;
                  end
               end
            end
         end

         iowt_pkg::ST_UPDATE: begin
            rsp_in       = '0;
            rsp_in.last  = 1'b1;
            pend_in      = '0;
            pend_vld_in  = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = iowt_pkg::ST_RESP;
            if (mode_ff == iowt_pkg::MODE_PARK) begin
               if (park_refuse) begin
                  rsp_in.status = iowt_pkg::STATUS_REFUSED;
               end else begin
                  ram_wr_en            = 1'b1;
                  used_in[sel_idx]     = 1'b1;
                  rvalid_in[sel_idx]   = park_int[iowt_pkg::EV_READ_BIT];
                  wvalid_in[sel_idx]   = park_int[iowt_pkg::EV_WRITE_BIT];
                  rsp_in.status        = iowt_pkg::STATUS_PARKED;
                  rsp_in.old_interest  = old_int;
                  rsp_in.new_interest  = park_int;
               end
            end else begin
               rsp_in.status = iowt_pkg::STATUS_WAKE;
               if (found_ff) begin
                  rvalid_in[sel_idx]  = rv_new;
                  wvalid_in[sel_idx]  = wv_new;
                  if (wake_int == 2'b00) begin
                     used_in[sel_idx] = 1'b0;
                  end
                  rsp_in.old_interest = old_int;
                  rsp_in.new_interest = wake_int;
                  if (wake_r || wake_w) begin
                     rsp_in.woken_valid   = 1'b1;
                     rsp_in.woken_success = succ_ff;
                     rsp_in.woken_task    = wake_r ? entry_ff.rtask : entry_ff.wtask;
                  end
                  if (wake_r && wake_w) begin
                     rsp_in.last   = 1'b0;
                     pend_in       = rsp_in;
                     pend_in.woken_task = entry_ff.wtask;
                     pend_in.last  = 1'b1;
                     pend_vld_in   = 1'b1;
                  end
               end
            end
         end

         iowt_pkg::ST_RESP: begin
            if (rsp_ready) begin
               if (pend_vld_ff) begin
                  rsp_in      = pend_ff;
                  pend_vld_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = iowt_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = iowt_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iowt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff   <= 1'b0;
         used_ff      <= '0;
         rvalid_ff    <= '0;
         wvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         shutdown_ff  <= 1'b0;
      end else begin
         chk_vld_ff   <= chk_vld_in;
         used_ff      <= used_in;
         rvalid_ff    <= rvalid_in;
         wvalid_ff    <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff  <= pend_vld_in;
         if (csr_valid && csr_ready) begin
            shutdown_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         mode_ff   <= req_mode;
         handle_ff <= req_handle;
         ev_ff     <= req_event_mask;
         task_ff   <= req_task_id;
         succ_ff   <= req_success_flag;
      end
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      entry_ff      <= entry_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
      pend_ff       <= pend_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_woken_valid   = rsp_ff.woken_valid;
   assign rsp_woken_task    = rsp_ff.woken_task;
   assign rsp_woken_success = rsp_ff.woken_success;
   assign rsp_old_interest  = rsp_ff.old_interest;
   assign rsp_new_interest  = rsp_ff.new_interest;
   assign rsp_last          = rsp_ff.last;

   // a waiter is only ever recorded on a slot that is in use
   a_valid_in_used: assert property (@(posedge clock) disable iff (reset)
      ((rvalid_ff | wvalid_ff) & ~used_ff) == '0)
      else $error("waiter recorded on a free slot");

   // a second woken task is pending, so the shown item cannot be the last one
   a_pend_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pend_vld_ff |-> !rsp_ff.last)
      else $error("last flag set while a result is pending");

   // one item at a time: no new request while a result is shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff && !pend_vld_ff)
      else $error("request accepted while results outstanding");

   // only a wake names a woken task
   a_woken_is_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.woken_valid |-> rsp_ff.status == iowt_pkg::STATUS_WAKE)
      else $error("woken task on a park result");

endmodule

### sv/iowt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iowt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
